/* rtl/core/bps_pkg.sv */
// ----------------------------------------------------------------------------
// Blinn-Phong shading package
// Payload types, fixed-point widths and register codes shared by the
// point-light shading core and its vector normaliser.
// ----------------------------------------------------------------------------
package bps_pkg;

    // Fragment beat as delivered by the rasteriser
    typedef struct packed {
        logic [15:0]        base_blue;
        logic [15:0]        base_green;
        logic [15:0]        base_red;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_shade_in;

    // Shaded pixel beat
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_shade_out;

    // Configuration register map (word index)
    typedef enum logic [2:0] {
        REG_LIGHT_X = 3'd0,
        REG_LIGHT_Y = 3'd1,
        REG_LIGHT_Z = 3'd2,
        REG_EYE_X   = 3'd3,
        REG_EYE_Y   = 3'd4,
        REG_EYE_Z   = 3'd5
    } t_reg_idx;

    localparam int SHININESS_DEF = 50;

    // Normaliser: magnitudes are aligned so the largest has its top bit at NT
    localparam int NT   = 29;
    localparam int AN   = NT + 1;      // aligned magnitude width
    localparam int SQW  = 2 * AN;      // one square
    localparam int SUMW = SQW + 2;     // sum of three squares
    localparam int RW   = SUMW / 2;    // integer square root width
    localparam int QB   = 16;          // fraction bits of a unit component
    localparam int NUMW = AN + QB;     // dividend width
    localparam int QW   = QB + 1;      // quotient width (unit may reach 1.0)
    localparam int UW   = QW + 1;      // signed unit component

    // Shading datapath
    localparam int DW   = 33;          // position difference
    localparam int HW   = UW + 1;      // sum of two unit components
    localparam int PW   = UW + 16;     // unit times normal
    localparam int DTW  = PW + 2;      // three-term dot product
    localparam int S24W = 27;          // Q.24 dot for the power chain
    localparam int LW   = 19;          // Q.16 lambert
    localparam int SPW  = 35;          // specular, Q.24 capped at 1024.0
    localparam int PRW  = SPW + S24W;  // power chain product
    localparam int TW   = 43;          // colour term
    localparam int FW   = TW + LW;     // colour term times lambert

    localparam logic [SPW-1:0] SPEC_ONE = SPW'(1) << 24;
    localparam logic [SPW-1:0] SPEC_CAP = SPW'(1) << 34;

endpackage

/* rtl/core/bps_norm.sv */
// ----------------------------------------------------------------------------
// Vector normaliser
// Pipelined fixed-point normalisation of a three-component signed vector to
// a Q.16 unit vector: alignment, sum of squares, bit-per-stage square root
// and bit-per-stage division. A zero vector gives the zero vector. A side
// word rides along unchanged. One vector per cycle.
// ----------------------------------------------------------------------------
module bps_norm #(
    parameter int IW = 33,
    parameter int SW = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [2:0][IW-1:0]          i_vec,
    input  logic [SW-1:0]               i_side,
    output logic                        o_valid,
    output logic [2:0][bps_pkg::UW-1:0] o_unit,
    output logic [SW-1:0]               o_side
);
    import bps_pkg::*;

    localparam int BW = $clog2(IW);

    // Stage registers
    logic                r1_v, r2_v, r3_v, r4_v;
    logic [2:0][IW-1:0]  r1_mag, r2_mag;
    logic [2:0]          r1_neg, r2_neg, r3_neg, r4_neg;
    logic [SW-1:0]       r1_side, r2_side, r3_side, r4_side;
    logic [BW-1:0]       r2_b;
    logic                r2_zero, r3_zero, r4_zero;
    logic [2:0][AN-1:0]  r3_a, r4_a;
    logic [2:0][SQW-1:0] r4_sq;

    logic [IW-1:0]       n_or;
    logic [BW-1:0]       n_b;

    // Square root stages
    logic [SUMW-1:0]     r_srem  [0:RW];
    logic [RW-1:0]       r_sroot [0:RW];
    logic [2:0][AN-1:0]  r_sa    [0:RW];
    logic [2:0]          r_sneg  [0:RW];
    logic                r_szero [0:RW];
    logic [SW-1:0]       r_sside [0:RW];
    logic                r_sv    [0:RW];

    // Division stages
    logic [2:0][NUMW-1:0] r_drem  [0:QW];
    logic [2:0][QW-1:0]   r_dq    [0:QW];
    logic [RW-1:0]        r_dlen  [0:QW];
    logic [2:0]           r_dneg  [0:QW];
    logic                 r_dzero [0:QW];
    logic [SW-1:0]        r_dside [0:QW];
    logic                 r_dv    [0:QW];

    // Valid bits through the front, load and output stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
            r_sv[0]  <= 1'b0;
            r_dv[0]  <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r1_v     <= i_valid;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            r4_v     <= r3_v;
            r_sv[0]  <= r4_v;
            r_dv[0]  <= r_sv[RW];
            o_valid  <= r_dv[QW];
        end
    end

    // Find the top set bit of the largest magnitude
    always_comb begin
        n_or = r1_mag[0] | r1_mag[1] | r1_mag[2];
        n_b  = '0;
        for (int k = 0; k < IW; k++) begin
            if (n_or[k]) begin
                n_b = BW'(k);
            end
        end
    end

    // Magnitudes, alignment, squares and their sum
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r1_neg[c] <= i_vec[c][IW-1];
            r1_mag[c] <= i_vec[c][IW-1] ? (~i_vec[c] + IW'(1)) : i_vec[c];
        end
        r1_side <= i_side;

        r2_mag  <= r1_mag;
        r2_neg  <= r1_neg;
        r2_side <= r1_side;
        r2_b    <= n_b;
        r2_zero <= (n_or == '0);

        for (int c = 0; c < 3; c++) begin
            r3_a[c] <= AN'({r2_mag[c], {NT{1'b0}}} >> r2_b);
        end
        r3_neg  <= r2_neg;
        r3_zero <= r2_zero;
        r3_side <= r2_side;

        for (int c = 0; c < 3; c++) begin
            r4_sq[c] <= SQW'(r3_a[c]) * SQW'(r3_a[c]);
        end
        r4_a    <= r3_a;
        r4_neg  <= r3_neg;
        r4_zero <= r3_zero;
        r4_side <= r3_side;

        r_srem[0]  <= SUMW'(r4_sq[0]) + SUMW'(r4_sq[1]) + SUMW'(r4_sq[2]);
        r_sroot[0] <= '0;
        r_sa[0]    <= r4_a;
        r_sneg[0]  <= r4_neg;
        r_szero[0] <= r4_zero;
        r_sside[0] <= r4_side;
    end

    // Square root, one result bit per stage, most significant first
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int SB = RW - 1 - k;
        logic [SUMW:0] trial;
        logic          take;

        assign trial = ((SUMW + 1)'(r_sroot[k]) << (SB + 1)) + ((SUMW + 1)'(1) << (2 * SB));
        assign take  = ({1'b0, r_srem[k]} >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_srem[k+1]  <= take ? SUMW'({1'b0, r_srem[k]} - trial) : r_srem[k];
            r_sroot[k+1] <= take ? (r_sroot[k] | (RW'(1) << SB)) : r_sroot[k];
            r_sa[k+1]    <= r_sa[k];
            r_sneg[k+1]  <= r_sneg[k];
            r_szero[k+1] <= r_szero[k];
            r_sside[k+1] <= r_sside[k];
        end
    end

    // Load the dividers
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_drem[0][c] <= {r_sa[RW][c], {QB{1'b0}}};
            r_dq[0][c]   <= '0;
        end
        r_dlen[0]  <= r_sroot[RW];
        r_dneg[0]  <= r_sneg[RW];
        r_dzero[0] <= r_szero[RW];
        r_dside[0] <= r_sside[RW];
    end

    // Restoring division, one quotient bit per stage on all three lanes
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int QS = QW - 1 - j;
        logic [NUMW:0] dsh;
        logic [2:0]    take;

        assign dsh = (NUMW + 1)'(r_dlen[j]) << QS;

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                take[c] = ({1'b0, r_drem[j][c]} >= dsh);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else begin
                r_dv[j+1] <= r_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int c = 0; c < 3; c++) begin
                r_drem[j+1][c] <= take[c] ? NUMW'({1'b0, r_drem[j][c]} - dsh) : r_drem[j][c];
                r_dq[j+1][c]   <= take[c] ? (r_dq[j][c] | (QW'(1) << QS)) : r_dq[j][c];
            end
            r_dlen[j+1]  <= r_dlen[j];
            r_dneg[j+1]  <= r_dneg[j];
            r_dzero[j+1] <= r_dzero[j];
            r_dside[j+1] <= r_dside[j];
        end
    end

    // Apply signs; a zero vector stays zero
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (r_dzero[QW]) begin
                o_unit[c] <= '0;
            end else if (r_dneg[QW][c]) begin
                o_unit[c] <= UW'(0) - UW'(r_dq[QW][c]);
            end else begin
                o_unit[c] <= UW'(r_dq[QW][c]);
            end
        end
        o_side <= r_dside[QW];
    end

endmodule

/* rtl/core/blinn_phong_fragment_shade_core.sv */
// ----------------------------------------------------------------------------
// Blinn-Phong fragment shading core
// One point light, per-fragment shading in fixed point, one fragment a cycle.
//
// Usage:
//   Light and camera positions are set over the APB port (word registers
//   light_x/y/z at 0x00..0x08, eye_x/y/z at 0x0C..0x14, Q16.16) while no
//   fragment is in flight. A fragment beat is taken on i_frag at every clock
//   edge where start is high; busy is never raised, so a beat may follow in
//   each cycle. Each fragment yields one pixel beat on o_pix, marked by
//   o_done for a single cycle, in order of arrival.
//   The path runs through two normalisers in series, each built from its
//   bit-per-stage square root and divider, then one multiply stage per
//   step of the specular power.
//   Throughput is one fragment per cycle.
//   Reset zeroes the configuration registers and valid bits, emptying the
//   pipeline. The receiver takes every pixel beat; there is no back-pressure.
// ----------------------------------------------------------------------------
module blinn_phong_fragment_shade_core #(
    parameter int SHININESS = bps_pkg::SHININESS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // fragment channel
    input  logic               start,
    output logic               busy,
    input  bps_pkg::t_shade_in i_frag,
    // pixel channel
    output logic               o_done,
    output bps_pkg::t_shade_out o_pix,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bps_pkg::*;

    localparam int SW3 = 3 * UW + 96;

    // Configuration registers
    logic [31:0] r_light_x, r_light_y, r_light_z;
    logic [31:0] r_eye_x, r_eye_y, r_eye_z;
    logic        n_wr;
    t_reg_idx    n_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign n_wr   = psel & penable & pwrite & pready;
    assign n_idx  = t_reg_idx'(paddr[4:2]);

    // Take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
            r_light_z <= '0;
            r_eye_x   <= '0;
            r_eye_y   <= '0;
            r_eye_z   <= '0;
        end else if (n_wr) begin
            unique case (n_idx)
                REG_LIGHT_X: r_light_x <= pwdata;
                REG_LIGHT_Y: r_light_y <= pwdata;
                REG_LIGHT_Z: r_light_z <= pwdata;
                REG_EYE_X:   r_eye_x   <= pwdata;
                REG_EYE_Y:   r_eye_y   <= pwdata;
                REG_EYE_Z:   r_eye_z   <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (n_idx)
            REG_LIGHT_X: prdata = r_light_x;
            REG_LIGHT_Y: prdata = r_light_y;
            REG_LIGHT_Z: prdata = r_light_z;
            REG_EYE_X:   prdata = r_eye_x;
            REG_EYE_Y:   prdata = r_eye_y;
            REG_EYE_Z:   prdata = r_eye_z;
            default:     prdata = '0;
        endcase
    end

    // Entry stage: vectors to light and camera
    logic                r_a_v;
    logic [2:0][DW-1:0]  r_a_dl, r_a_de;
    logic [2:0][15:0]    r_a_base, r_a_nrm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_dl[0] <= DW'($signed(r_light_x)) - DW'(i_frag.point_x);
        r_a_dl[1] <= DW'($signed(r_light_y)) - DW'(i_frag.point_y);
        r_a_dl[2] <= DW'($signed(r_light_z)) - DW'(i_frag.point_z);
        r_a_de[0] <= DW'($signed(r_eye_x)) - DW'(i_frag.point_x);
        r_a_de[1] <= DW'($signed(r_eye_y)) - DW'(i_frag.point_y);
        r_a_de[2] <= DW'($signed(r_eye_z)) - DW'(i_frag.point_z);
        r_a_base  <= {i_frag.base_blue, i_frag.base_green, i_frag.base_red};
        r_a_nrm   <= {i_frag.normal_z, i_frag.normal_y, i_frag.normal_x};
    end

    // Unit light and eye vectors
    logic               l_valid, e_valid;
    logic [2:0][UW-1:0] l_unit, e_unit;
    logic [47:0]        l_side, e_side;

    bps_norm #(.IW(DW), .SW(48)) u_norm_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_v),
        .i_vec   (r_a_dl),
        .i_side  (r_a_base),
        .o_valid (l_valid),
        .o_unit  (l_unit),
        .o_side  (l_side)
    );

    bps_norm #(.IW(DW), .SW(48)) u_norm_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_v),
        .i_vec   (r_a_de),
        .i_side  (r_a_nrm),
        .o_valid (e_valid),
        .o_unit  (e_unit),
        .o_side  (e_side)
    );

    // Half vector
    logic [2:0][HW-1:0] n_hs;
    logic               h_valid;
    logic [2:0][UW-1:0] h_unit;
    logic [SW3-1:0]     h_side;
    logic [2:0][UW-1:0] h_lvec;
    logic [2:0][15:0]   h_base, h_nrm;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_hs[c] = HW'($signed(l_unit[c])) + HW'($signed(e_unit[c]));
        end
    end

    bps_norm #(.IW(HW), .SW(SW3)) u_norm_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (l_valid & e_valid),
        .i_vec   (n_hs),
        .i_side  ({l_unit, l_side, e_side}),
        .o_valid (h_valid),
        .o_unit  (h_unit),
        .o_side  (h_side)
    );

    assign h_lvec = h_side[SW3-1:96];
    assign h_base = h_side[95:48];
    assign h_nrm  = h_side[47:0];

    // Dot products with the normal
    logic                  r_c_v, r_d_v;
    logic signed [PW-1:0]  r_c_ph [0:2];
    logic signed [PW-1:0]  r_c_pl [0:2];
    logic [2:0][15:0]      r_c_base, r_d_base;
    logic signed [DTW-1:0] r_d_sd, r_d_lam;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_c_ph[c] <= PW'($signed(h_unit[c])) * PW'($signed(h_nrm[c]));
            r_c_pl[c] <= PW'($signed(h_lvec[c])) * PW'($signed(h_nrm[c]));
        end
        r_c_base <= h_base;

        r_d_sd   <= DTW'(r_c_ph[0]) + DTW'(r_c_ph[1]) + DTW'(r_c_ph[2]);
        r_d_lam  <= DTW'(r_c_pl[0]) + DTW'(r_c_pl[1]) + DTW'(r_c_pl[2]);
        r_d_base <= r_c_base;
    end

    // Specular power chain
    logic [SPW-1:0]   r_sp   [0:SHININESS];
    logic [S24W-1:0]  r_s24  [0:SHININESS];
    logic [LW-1:0]    r_l16  [0:SHININESS];
    logic [2:0][15:0] r_pbase[0:SHININESS];
    logic             r_pv   [0:SHININESS];

    always_ff @(posedge i_clk) begin
        if (r_d_sd > 0) begin
            r_sp[0]  <= SPEC_ONE;
            r_s24[0] <= r_d_sd[S24W+5:6];
        end else begin
            r_sp[0]  <= '0;
            r_s24[0] <= '0;
        end
        r_l16[0]   <= (r_d_lam > 0) ? r_d_lam[LW+13:14] : '0;
        r_pbase[0] <= r_d_base;
    end

    for (genvar k = 0; k < SHININESS; k++) begin : g_pow
        logic [PRW-1:0]    prod;
        logic [PRW-25:0]   shr;

        assign prod = PRW'(r_sp[k]) * PRW'(r_s24[k]);
        assign shr  = prod[PRW-1:24];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pv[k+1] <= 1'b0;
            end else begin
                r_pv[k+1] <= r_pv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sp[k+1]    <= (shr > (PRW - 24)'(SPEC_CAP)) ? SPEC_CAP : shr[SPW-1:0];
            r_s24[k+1]   <= r_s24[k];
            r_l16[k+1]   <= r_l16[k];
            r_pbase[k+1] <= r_pbase[k];
        end
    end

    // Colour terms, lambert scaling and clamp
    logic              r_f1_v, r_f2_v;
    logic [2:0][TW-1:0] r_f1_term;
    logic [LW-1:0]     r_f1_l16;
    logic [2:0][FW-1:0] r_f2_prod;
    logic [2:0][7:0]   n_byte;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_f1_term[c] <= (TW'(r_pbase[SHININESS][c]) << 16)
                          + TW'(r_sp[SHININESS]) * TW'(255);
            r_f2_prod[c] <= FW'(r_f1_term[c]) * FW'(r_f1_l16);
        end
        r_f1_l16 <= r_l16[SHININESS];
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_byte[c] = (|r_f2_prod[c][FW-1:48]) ? 8'hFF : r_f2_prod[c][47:40];
        end
    end

    // Valid bits and the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v   <= 1'b0;
            r_d_v   <= 1'b0;
            r_pv[0] <= 1'b0;
            r_f1_v  <= 1'b0;
            r_f2_v  <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            r_c_v   <= h_valid;
            r_d_v   <= r_c_v;
            r_pv[0] <= r_d_v;
            r_f1_v  <= r_pv[SHININESS];
            r_f2_v  <= r_f1_v;
            o_done  <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_pix.out_red   <= n_byte[0];
        o_pix.out_green <= n_byte[1];
        o_pix.out_blue  <= n_byte[2];
    end

endmodule
